FILE: rtl/core/fixed_slice_free_list_allocator_unit_assert.svh
// Assertion macros for the slice allocator
`ifndef FIXED_SLICE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SLICE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define FSLA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fsla: invariant violated");

`define FSLA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsla: implication violated");

`else

`define FSLA_ASSERT(lbl, clk, rst, prop)

`define FSLA_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/fsla_pkg.sv
package fsla_pkg;

   localparam int MAX_SLICES_DEF  = 4096;
   localparam int ALIGN_BYTES_DEF = 8;

   localparam int HEADER_BYTES      = 8;
   localparam int SMALL_CHUNK_BYTES = 8192;
   localparam int LARGE_CHUNK_BYTES = 32768;
   localparam int SMALL_SLICE_LIMIT = 256;

   localparam int KIND_W        = 2;
   localparam int INDEX_W       = 12;
   localparam int COUNT_W       = 16;
   localparam int SLICE_BYTES_W = 16;
   localparam int MIN_SLICES_W  = 13;
   localparam int SIZE_W        = SLICE_BYTES_W + 1;
   localparam int QUOT_W        = 15;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   localparam logic [QUOT_W-1:0] SMALL_DIVIDEND = QUOT_W'(SMALL_CHUNK_BYTES - HEADER_BYTES);
   localparam logic [QUOT_W-1:0] LARGE_DIVIDEND = QUOT_W'(LARGE_CHUNK_BYTES - HEADER_BYTES);

   localparam logic [SLICE_BYTES_W-1:0] SLICE_BYTES_RESET = SLICE_BYTES_W'(64);

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLICE_BYTES = 1'd0,
      CSR_MIN_SLICES  = 1'd1
   } csr_index_type;

   typedef enum logic {
      ERR_NONE     = 1'b0,
      ERR_CAPACITY = 1'b1
   } error_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIZE,
      ST_DIV,
      ST_CHECK,
      ST_GROW,
      ST_POP,
      ST_POP_WAIT,
      ST_FREE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic              start;
      logic [QUOT_W-1:0] dividend;
      logic [QUOT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/fsla_chan_if.sv
interface fsla_req_if import fsla_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [INDEX_W-1:0] slice_index;

   modport source (output valid, output kind, output slice_index, input ready);
   modport sink   (input valid, input kind, input slice_index, output ready);
endinterface

interface fsla_rsp_if import fsla_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [INDEX_W-1:0] given_slice;
   logic               error_code;
   logic [COUNT_W-1:0] allocated_count;
   logic [COUNT_W-1:0] free_count;

   modport source (output valid, output ok, output given_slice, output error_code,
                   output allocated_count, output free_count, input ready);
   modport sink   (input valid, input ok, input given_slice, input error_code,
                   input allocated_count, input free_count, output ready);
endinterface

interface fsla_csr_if import fsla_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/fixed_slice_free_list_allocator_unit.sv
// Channel   Dir  Payload                                             Accepted when
// req_ch    in   kind, slice_index                                   valid & ready
// rsp_ch    out  ok, given_slice, error_code, allocated/free counts  valid & ready
// csr_ch    in   index, data (slice_bytes, min_slices)               valid & ready
//
// One request at a time. Allocate from a non-empty list pops the head (one read of
// the link memory) before the result register; free writes one link entry first.
// Allocate from an empty list adds the chunk build: divider (skipped for large
// slices) and check, then one link-memory write per slice of the chunk.
// Result sits in an output register; the next request is taken while it waits.
// Synchronous reset; link memory is not cleared (only written entries are read).
`include "fixed_slice_free_list_allocator_unit_assert.svh"

module fixed_slice_free_list_allocator_unit import fsla_pkg::*; #(
   parameter int MAX_SLICES  = MAX_SLICES_DEF,
   parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fsla_req_if.sink   req_ch,
   fsla_rsp_if.source rsp_ch,
   fsla_csr_if.sink   csr_ch
);

   localparam int IDX_W  = $clog2(MAX_SLICES);
   localparam int HEAD_W = IDX_W + 1;
   localparam int IDXC_W = (HEAD_W > INDEX_W) ? HEAD_W : INDEX_W;
   localparam int CMP_W  = ((HEAD_W > QUOT_W) ? HEAD_W : QUOT_W) + 1;
   localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(MAX_SLICES);
   localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

   state_type state_ff, state_in;

   logic [SLICE_BYTES_W-1:0] slice_bytes_ff;
   logic [MIN_SLICES_W-1:0]  min_slices_ff;
   logic [HEAD_W-1:0]        head_ff;
   logic [HEAD_W-1:0]        in_use_ff;
   logic [COUNT_W-1:0]       alloc_total_ff;
   logic [COUNT_W-1:0]       free_total_ff;
   logic [QUOT_W-1:0]        n_ff;
   logic [QUOT_W-1:0]        grow_cnt_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     res_ok_ff;
   logic                     res_err_ff;
   logic [INDEX_W-1:0]       res_given_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic [INDEX_W-1:0]       rsp_given_ff;
   logic                     rsp_err_ff;
   logic [COUNT_W-1:0]       rsp_alloc_ff;
   logic [COUNT_W-1:0]       rsp_free_ff;

   logic                     req_fire;
   kind_type                 req_kind;
   logic [IDXC_W-1:0]        idx_wide;
   logic                     idx_ok;
   logic                     list_empty;
   logic [SIZE_W-1:0]        size_raw;
   logic [SIZE_W-1:0]        size;
   logic                     size_large;
   logic                     size_small;
   logic [QUOT_W-1:0]        min_w;
   logic [QUOT_W-1:0]        n_eff;
   logic [HEAD_W-1:0]        cap;
   logic                     cap_fail;
   logic [HEAD_W-1:0]        grow_slot;
   logic                     grow_last;
   logic                     slot_free;
   logic                     rsp_load;

   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [HEAD_W-1:0]        mem_rdata;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign req_kind   = kind_type'(req_ch.kind);
   assign idx_wide   = IDXC_W'(req_ch.slice_index);
   assign idx_ok     = idx_wide < IDXC_W'(MAX_SLICES);
   assign list_empty = head_ff == HEAD_EMPTY;

   assign size_raw   = (SIZE_W'(slice_bytes_ff) + ALIGN_MASK) & ~ALIGN_MASK;
   assign size       = (size_raw == '0) ? SIZE_W'(ALIGN_BYTES) : size_raw;
   assign size_large = size >= SIZE_W'(LARGE_CHUNK_BYTES);
   assign size_small = size < SIZE_W'(SMALL_SLICE_LIMIT);

   assign min_w    = QUOT_W'(min_slices_ff);
   assign n_eff    = (min_slices_ff != '0 && n_ff < min_w) ? min_w : n_ff;
   assign cap      = HEAD_EMPTY - in_use_ff;
   assign cap_fail = CMP_W'(n_eff) > CMP_W'(cap);

   assign grow_slot = in_use_ff + HEAD_W'(grow_cnt_ff);
   assign grow_last = grow_cnt_ff == n_ff - QUOT_W'(1);

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load  = (state_ff == ST_RESPOND) && slot_free;

   assign div_req.start    = (state_ff == ST_SIZE) && !size_large;
   assign div_req.dividend = size_small ? SMALL_DIVIDEND : LARGE_DIVIDEND;
   assign div_req.divisor  = size[QUOT_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  KIND_ALLOC: state_in = list_empty ? ST_SIZE : ST_POP;
                  KIND_FREE:  state_in = idx_ok ? ST_FREE : ST_RESPOND;
                  KIND_CLEAR: state_in = ST_RESPOND;
                  default:    state_in = ST_RESPOND;
               endcase
            end
         end
         ST_SIZE:     state_in = size_large ? ST_CHECK : ST_DIV;
         ST_DIV:      state_in = div_rsp.done ? ST_CHECK : ST_DIV;
         ST_CHECK:    state_in = cap_fail ? ST_RESPOND : ST_GROW;
         ST_GROW:     state_in = grow_last ? ST_POP : ST_GROW;
         ST_POP:      state_in = ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_RESPOND;
         ST_FREE:     state_in = ST_RESPOND;
         ST_RESPOND:  state_in = slot_free ? ST_IDLE : ST_RESPOND;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready  = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_GROW: begin
            mem_we    = 1'b1;
            mem_waddr = grow_slot[IDX_W-1:0];
         end
         ST_FREE: mem_we = 1'b1;
         default: begin
         end
      endcase
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slice_bytes_ff <= SLICE_BYTES_RESET;
         min_slices_ff  <= '0;
         head_ff        <= HEAD_EMPTY;
         in_use_ff      <= '0;
         alloc_total_ff <= '0;
         free_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            unique case (csr_index_type'(csr_ch.index))
               CSR_SLICE_BYTES: slice_bytes_ff <= csr_ch.data;
               CSR_MIN_SLICES:  min_slices_ff  <= csr_ch.data[MIN_SLICES_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_fire && req_kind == KIND_CLEAR) begin
            head_ff   <= HEAD_EMPTY;
            in_use_ff <= '0;
         end
         if (state_ff == ST_GROW) begin
            head_ff <= grow_slot;
            if (grow_last) begin
               in_use_ff     <= in_use_ff + HEAD_W'(n_ff);
               free_total_ff <= free_total_ff + COUNT_W'(n_ff);
            end
         end
         if (state_ff == ST_POP_WAIT) begin
            head_ff        <= mem_rdata;
            alloc_total_ff <= alloc_total_ff + COUNT_W'(1);
            free_total_ff  <= free_total_ff - COUNT_W'(1);
         end
         if (state_ff == ST_FREE) begin
            head_ff        <= HEAD_W'(idx_ff);
            alloc_total_ff <= alloc_total_ff - COUNT_W'(1);
            free_total_ff  <= free_total_ff + COUNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         idx_ff       <= IDX_W'(idx_wide);
         res_ok_ff    <= (req_kind == KIND_CLEAR);
         res_err_ff   <= ERR_NONE;
         res_given_ff <= '0;
      end
      if (state_ff == ST_SIZE && size_large) begin
         n_ff <= QUOT_W'(1);
      end
      if (state_ff == ST_DIV && div_rsp.done) begin
         n_ff <= div_rsp.quotient;
      end
      if (state_ff == ST_CHECK) begin
         n_ff        <= n_eff;
         grow_cnt_ff <= '0;
         res_err_ff  <= cap_fail ? ERR_CAPACITY : ERR_NONE;
      end
      if (state_ff == ST_GROW) begin
         grow_cnt_ff <= grow_cnt_ff + QUOT_W'(1);
      end
      if (state_ff == ST_POP) begin
         res_given_ff <= INDEX_W'(head_ff);
         res_ok_ff    <= 1'b1;
      end
      if (state_ff == ST_FREE) begin
         res_ok_ff <= 1'b1;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_given_ff <= res_given_ff;
         rsp_err_ff   <= res_err_ff;
         rsp_alloc_ff <= alloc_total_ff;
         rsp_free_ff  <= free_total_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ok              = rsp_ok_ff;
   assign rsp_ch.given_slice     = rsp_given_ff;
   assign rsp_ch.error_code      = rsp_err_ff;
   assign rsp_ch.allocated_count = rsp_alloc_ff;
   assign rsp_ch.free_count      = rsp_free_ff;

   fsla_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fsla_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (MAX_SLICES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (head_ff),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   `FSLA_ASSERT(a_in_use_bound, clock, reset, in_use_ff <= HEAD_EMPTY)
   `FSLA_ASSERT(a_head_bound, clock, reset, head_ff <= HEAD_EMPTY)
   `FSLA_ASSERT_IMP(a_grow_in_pool, clock, reset, state_ff == ST_GROW, grow_slot < HEAD_EMPTY)
   `FSLA_ASSERT_IMP(a_idle_div_quiet, clock, reset, state_ff == ST_IDLE, !div_rsp.busy)
   `FSLA_ASSERT_IMP(a_pop_has_entry, clock, reset, state_ff == ST_POP, !list_empty)

endmodule

FILE: rtl/core/fsla_ram.sv
module fsla_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/fsla_div.sv
// Restoring divider, one quotient bit per cycle
module fsla_div import fsla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [QUOT_W-1:0] rem_ff;
   logic [QUOT_W-1:0] quo_ff;
   logic [QUOT_W-1:0] dvs_ff;

   logic [QUOT_W:0]   trial;
   logic [QUOT_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];
         quo_ff <= {quo_ff[QUOT_W-2:0], fits};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: tb/sv/tb_fixed_slice_free_list_allocator_unit.sv
module tb_fixed_slice_free_list_allocator_unit;
   import fsla_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SLICES = MAX_SLICES_DEF;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] slice_index;
   } pool_op_t;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] given_slice;
      error_type          error_code;
      logic [COUNT_W-1:0] allocated_count;
      logic [COUNT_W-1:0] free_count;
   } pool_reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsla_req_if req_ch();
   fsla_rsp_if rsp_ch();
   fsla_csr_if csr_ch();

   fixed_slice_free_list_allocator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // pool mirror
   logic [12:0]             top_slice;
   logic [12:0]             link_mem [POOL_SLICES];
   logic [12:0]             carved;
   logic [COUNT_W-1:0]      out_total;
   logic [COUNT_W-1:0]      idle_total;
   logic [SLICE_BYTES_W-1:0] pool_bytes;
   logic [MIN_SLICES_W-1:0] pool_min;

   pool_op_t           queued_ops[$];
   pool_reply_t        due_replies[$];
   logic [INDEX_W-1:0] held_slices[$];

   logic fast_phase = 1'b0;
   int   fail_count = 0;
   int   ops_queued = 0;
   int   ops_accepted = 0;
   int   replies_seen = 0;
   int   chunks_carved = 0;
   int   capacity_refusals = 0;
   int   csr_writes = 0;
   int   issue_gap = 0;
   int   rsp_wait = 0;
   int   hold_left = 0;
   pool_op_t next_op;

   function automatic int slices_per_chunk();
      int size;
      int n;
      size = (int'(pool_bytes) + ALIGN_BYTES_DEF - 1) & ~(ALIGN_BYTES_DEF - 1);
      if (size == 0)
         size = ALIGN_BYTES_DEF;
      if (size >= LARGE_CHUNK_BYTES)
         n = 1;
      else if (size < SMALL_SLICE_LIMIT)
         n = (SMALL_CHUNK_BYTES - HEADER_BYTES) / size;
      else
         n = (LARGE_CHUNK_BYTES - HEADER_BYTES) / size;
      if (pool_min != 0 && n < int'(pool_min))
         n = int'(pool_min);
      return n;
   endfunction

   task automatic apply_pool_op(input logic [KIND_W-1:0] kind,
                                input logic [INDEX_W-1:0] idx);
      pool_reply_t r;
      int n;
      int slot;
      logic fits;
      r = '0;
      r.error_code = ERR_NONE;
      if (kind == KIND_ALLOC) begin
         fits = 1'b1;
         if (int'(top_slice) >= POOL_SLICES) begin
            n = slices_per_chunk();
            if (n > POOL_SLICES - int'(carved)) begin
               fits = 1'b0;
               r.error_code = ERR_CAPACITY;
               capacity_refusals++;
            end else begin
               for (int i = 0; i < n; i++) begin
                  slot = int'(carved) + i;
                  link_mem[slot] = top_slice;
                  top_slice = 13'(slot);
               end
               carved = carved + 13'(n);
               idle_total = idle_total + COUNT_W'(n);
               chunks_carved++;
            end
         end
         if (fits) begin
            r.given_slice = top_slice[INDEX_W-1:0];
            top_slice = link_mem[top_slice[INDEX_W-1:0]];
            out_total = out_total + COUNT_W'(1);
            idle_total = idle_total - COUNT_W'(1);
            r.ok = 1'b1;
            held_slices.push_back(r.given_slice);
         end
      end else if (kind == KIND_FREE) begin
         link_mem[idx] = top_slice;
         top_slice = {1'b0, idx};
         out_total = out_total - COUNT_W'(1);
         idle_total = idle_total + COUNT_W'(1);
         r.ok = 1'b1;
      end else if (kind == KIND_CLEAR) begin
         top_slice = 13'(POOL_SLICES);
         carved = '0;
         held_slices.delete();
         r.ok = 1'b1;
      end
      r.allocated_count = out_total;
      r.free_count = idle_total;
      due_replies.push_back(r);
   endtask

   task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      fail_count++;
   endtask

   task automatic check_reply();
      pool_reply_t want;
      if (due_replies.size() == 0) begin
         $display("%0t: reply with none outstanding, expected nothing, actual ok=%0b slice=%0h",
                  $time, rsp_ch.ok, rsp_ch.given_slice);
         fail_count++;
      end else begin
         want = due_replies.pop_front();
         if (rsp_ch.ok !== want.ok)
            report("ok", 32'(want.ok), 32'(rsp_ch.ok));
         if (rsp_ch.given_slice !== want.given_slice)
            report("given_slice", 32'(want.given_slice), 32'(rsp_ch.given_slice));
         if (rsp_ch.error_code !== want.error_code)
            report("error_code", 32'(want.error_code), 32'(rsp_ch.error_code));
         if (rsp_ch.allocated_count !== want.allocated_count)
            report("allocated_count", 32'(want.allocated_count), 32'(rsp_ch.allocated_count));
         if (rsp_ch.free_count !== want.free_count)
            report("free_count", 32'(want.free_count), 32'(rsp_ch.free_count));
      end
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         issue_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_pool_op(req_ch.kind, req_ch.slice_index);
            ops_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (issue_gap > 0) begin
               issue_gap--;
               req_ch.valid <= 1'b0;
            end else if (queued_ops.size() > 0) begin
               next_op = queued_ops.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.kind <= next_op.kind;
               req_ch.slice_index <= next_op.slice_index;
               issue_gap = fast_phase ? 0 : $urandom_range(0, 11);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // reply side; one long hold-off part way through to back the pool up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_reply();
            replies_seen++;
            rsp_wait = fast_phase ? 0 : $urandom_range(0, 11);
            if (replies_seen == 600)
               hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx);
      pool_op_t op;
      while (queued_ops.size() >= 4)
         @(negedge clock);
      op.kind = kind;
      op.slice_index = idx;
      queued_ops.push_back(op);
      ops_queued++;
   endtask

   task automatic queue_random_op();
      int roll;
      int pick;
      logic [INDEX_W-1:0] idx;
      roll = $urandom_range(0, 99);
      idx = INDEX_W'($urandom_range(0, 4095));
      if (roll < 55) begin
         queue_op(KIND_ALLOC, idx);
      end else if (roll < 88 && held_slices.size() > 0) begin
         pick = $urandom_range(0, held_slices.size() - 1);
         idx = held_slices[pick];
         held_slices.delete(pick);
         queue_op(KIND_FREE, idx);
      end else if (roll < 96) begin
         queue_op(KIND_FREE, idx);
      end else if (roll < 99) begin
         queue_op(KIND_UNKNOWN, idx);
      end else begin
         queue_op(KIND_CLEAR, idx);
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (queued_ops.size() != 0 || req_ch.valid || due_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= which;
      csr_ch.data <= value;
      do
         @(posedge clock);
      while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      if (which == CSR_SLICE_BYTES)
         pool_bytes = value;
      else
         pool_min = value[MIN_SLICES_W-1:0];
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_pool(input logic [SLICE_BYTES_W-1:0] bytes,
                           input logic [MIN_SLICES_W-1:0] min_count);
      wait_drained();
      write_csr(CSR_SLICE_BYTES, bytes);
      write_csr(CSR_MIN_SLICES, CSR_DATA_W'(min_count));
   endtask

   initial begin
      int k;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ALLOC;
      req_ch.slice_index = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_SLICE_BYTES;
      csr_ch.data = '0;
      top_slice = 13'(POOL_SLICES);
      carved = '0;
      out_total = '0;
      idle_total = '0;
      pool_bytes = SLICE_BYTES_RESET;
      pool_min = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: LIFO reuse, unchecked and double frees, unknown kind
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_ALLOC, 12'hFFF);
      queue_op(KIND_FREE, 12'd126);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_FREE, 12'hFFF);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_FREE, 12'd0);
      queue_op(KIND_FREE, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_UNKNOWN, 12'hFFF);
      queue_op(KIND_CLEAR, 12'd0);
      queue_op(KIND_FREE, 12'hAAA);
      queue_op(KIND_FREE, 12'h555);

      // one slice carved, then a chunk of the whole pool no longer fits
      set_pool(16'hFFFF, 13'd0);
      queue_op(KIND_CLEAR, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);
      set_pool(16'hFFFF, 13'd4096);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_FREE, 12'd7);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);
      queue_op(KIND_CLEAR, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);

      set_pool(16'd0, 13'd0);
      queue_op(KIND_CLEAR, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);
      set_pool(16'd248, 13'd5);
      queue_op(KIND_CLEAR, 12'd0);
      queue_op(KIND_ALLOC, 12'd0);

      for (int p = 0; p < 16; p++) begin
         case (p % 8)
            0: set_pool(16'd64, 13'd0);
            1: set_pool(16'hFFFF, 13'd0);
            2: set_pool(16'($urandom_range(256, 32767)), 13'd0);
            3: set_pool(16'($urandom_range(1, 255)), 13'd0);
            4: set_pool(16'($urandom_range(1, 65535)), 13'($urandom_range(1, 40)));
            5: begin
               set_pool(16'd1, 13'd4096);
               queue_op(KIND_CLEAR, 12'd0);
            end
            6: begin
               set_pool(16'hFFFF, 13'd0);
               queue_op(KIND_CLEAR, 12'd0);
               k = $urandom_range(1, 20);
               repeat (k) queue_op(KIND_ALLOC, INDEX_W'($urandom_range(0, 4095)));
               set_pool(16'hFFFF, 13'($urandom_range(4097 - k, 4096)));
               queue_op(KIND_ALLOC, 12'd0);
               queue_op(KIND_ALLOC, 12'hFFF);
            end
            default: set_pool(16'($urandom_range(32761, 65535)), 13'($urandom_range(0, 3)));
         endcase
         fast_phase = (p % 4 == 2);
         repeat (100) queue_random_op();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests and %0d replies over %0d register writes;", ops_accepted,
               replies_seen, csr_writes);
      $display("%0d chunks carved, %0d allocations refused for lack of room.", chunks_carved,
               capacity_refusals);
      if (fail_count == 0) begin
         $display("** fixed_slice_free_list_allocator_unit: PASSED **");
      end else begin
         $display("** fixed_slice_free_list_allocator_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #15ms;
      $display("** fixed_slice_free_list_allocator_unit: FAILED **");
      $finish;
   end

endmodule
